// ===== rtl/rational_fraction_alu_macros.svh =====
// ----------------------------------------------------------------------------
// Rational fraction ALU assertion macros
// Shared concurrent assertion forms for the rational fraction ALU.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_FRACTION_ALU_MACROS_SVH
`define RATIONAL_FRACTION_ALU_MACROS_SVH

// check a consequence in the same cycle
`define RFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the next cycle
`define RFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational fraction ALU package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rfa_pkg;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int ACTION_W          = 2;
	localparam int RES_NUM_W         = 33;
	localparam int RES_DEN_W         = 32;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MSEL_AN_BD = 2'd0,
		MSEL_AD_BN = 2'd1,
		MSEL_AD_BD = 2'd2,
		MSEL_AN_BN = 2'd3
	} msel_t;

	typedef enum logic [1:0] {
		DST_NONE = 2'd0,
		DST_T1   = 2'd1,
		DST_T2   = 2'd2,
		DST_DEN  = 2'd3
	} mdst_t;

	typedef struct packed {
		logic  capture;
		msel_t msel;
		mdst_t mdst;
		logic  sum;
		logic  gcd_step;
		logic  div_init;
		logic  div_step;
		logic  load_res;
		logic  load_err;
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		logic    err;
		logic    gcd_done;
	} dp_sts_t;

endpackage

// ===== rtl/rational_fraction_alu.sv =====
// ----------------------------------------------------------------------------
// Rational fraction ALU
// Adds, subtracts, multiplies or divides two signed fractions and reduces the
// result by the GCD of its magnitudes; flags a zero result denominator.
//
//   Channel   Handshake              Payload
//   request   start / busy           action, a_num, a_den, b_num, b_den
//   result    done (one-cycle)       res_num, res_den, zero_denominator
//
// A request with a zero denominator, or a division by zero, returns its error
// result in the cycle after accept. Otherwise the block runs three multiply
// steps, a sum, the binary GCD loop (one step a cycle), a divider set-up and
// the bit-serial division; the GCD loop and the dividers dominate its time.
// busy stays high until the result cycle; a new request may start then.
// Reset clears the controller; the result registers are not reset.
// ----------------------------------------------------------------------------
module rational_fraction_alu #(
	parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rfa_pkg::ACTION_W-1:0]         action,
	input  logic signed [OPERAND_WIDTH-1:0]      a_num,
	input  logic signed [OPERAND_WIDTH-1:0]      a_den,
	input  logic signed [OPERAND_WIDTH-1:0]      b_num,
	input  logic signed [OPERAND_WIDTH-1:0]      b_den,
	output logic                                 done,
	output logic signed [rfa_pkg::RES_NUM_W-1:0] res_num,
	output logic signed [rfa_pkg::RES_DEN_W-1:0] res_den,
	output logic                                 zero_denominator
);
	import rfa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rfa_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.sts   (sts),
		.cmd   (cmd)
	);

	rfa_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk             (clk),
		.cmd             (cmd),
		.sts             (sts),
		.action          (action),
		.a_num           (a_num),
		.a_den           (a_den),
		.b_num           (b_num),
		.b_den           (b_den),
		.res_num         (res_num),
		.res_den         (res_den),
		.zero_denominator(zero_denominator)
	);

endmodule

// ===== rtl/rfa_datapath.sv =====
// ----------------------------------------------------------------------------
// Rational fraction ALU datapath
// Sign-magnitude operands, shared multiplier, binary GCD and two restoring
// dividers that reduce numerator and denominator in parallel.
// ----------------------------------------------------------------------------
module rfa_datapath #(
	parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                             clk,
	input  rfa_pkg::dp_cmd_t                 cmd,
	output rfa_pkg::dp_sts_t                 sts,
	input  logic [rfa_pkg::ACTION_W-1:0]     action,
	input  logic signed [OPERAND_WIDTH-1:0]  a_num,
	input  logic signed [OPERAND_WIDTH-1:0]  a_den,
	input  logic signed [OPERAND_WIDTH-1:0]  b_num,
	input  logic signed [OPERAND_WIDTH-1:0]  b_den,
	output logic signed [rfa_pkg::RES_NUM_W-1:0] res_num,
	output logic signed [rfa_pkg::RES_DEN_W-1:0] res_den,
	output logic                             zero_denominator
);
	import rfa_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * OPERAND_WIDTH;
	localparam int KW = $clog2(PW);
	localparam int XW = (PW > RES_NUM_W) ? PW : RES_NUM_W;

	action_t act_q;
	logic [W-1:0] an_mag_q, ad_mag_q, bn_mag_q, bd_mag_q;
	logic         an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;

	logic [PW-1:0] t1_mag_q, t2_mag_q, den_mag_q, num_mag_q;
	logic          t1_neg_q, t2_neg_q, den_neg_q, num_neg_q;

	logic [PW-1:0] x_q, y_q, g_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] rn_q, rd_q, qn_q, qd_q;

	logic [W-1:0]  mul_a, mul_b;
	logic          mul_sa, mul_sb;
	logic [PW-1:0] prod;
	logic          prod_neg;
	logic [PW-1:0] sum_mag;
	logic          sum_neg;
	logic [PW:0]   rn_sh, rd_sh;
	logic          rn_ge, rd_ge;
	logic [XW-1:0] num_ext, den_ext;

	assign sts.action   = act_q;
	assign sts.err      = (a_den == '0) || (b_den == '0) ||
	                      ((action_t'(action) == ACT_DIV) && (b_num == '0));
	assign sts.gcd_done = (x_q == '0) || (y_q == '0);

	always_comb begin
		mul_a  = an_mag_q;
		mul_b  = bd_mag_q;
		mul_sa = an_neg_q;
		mul_sb = bd_neg_q;
		case (cmd.msel)
			MSEL_AN_BD: begin
				mul_a  = an_mag_q;
				mul_b  = bd_mag_q;
				mul_sa = an_neg_q;
				mul_sb = bd_neg_q;
			end
			MSEL_AD_BN: begin
				mul_a  = ad_mag_q;
				mul_b  = bn_mag_q;
				mul_sa = ad_neg_q;
				mul_sb = bn_neg_q;
			end
			MSEL_AD_BD: begin
				mul_a  = ad_mag_q;
				mul_b  = bd_mag_q;
				mul_sa = ad_neg_q;
				mul_sb = bd_neg_q;
			end
			MSEL_AN_BN: begin
				mul_a  = an_mag_q;
				mul_b  = bn_mag_q;
				mul_sa = an_neg_q;
				mul_sb = bn_neg_q;
			end
			default: begin
				mul_a  = an_mag_q;
				mul_b  = bd_mag_q;
				mul_sa = an_neg_q;
				mul_sb = bd_neg_q;
			end
		endcase
	end

	assign prod     = PW'(mul_a) * PW'(mul_b);
	assign prod_neg = (mul_sa ^ mul_sb) && (prod != '0);

	always_comb begin
		if (t1_neg_q == t2_neg_q) begin
			sum_mag = t1_mag_q + t2_mag_q;
			sum_neg = t1_neg_q;
		end else if (t1_mag_q >= t2_mag_q) begin
			sum_mag = t1_mag_q - t2_mag_q;
			sum_neg = t1_neg_q;
		end else begin
			sum_mag = t2_mag_q - t1_mag_q;
			sum_neg = t2_neg_q;
		end
		if (sum_mag == '0) begin
			sum_neg = 1'b0;
		end
	end

	assign rn_sh = {rn_q, qn_q[PW-1]};
	assign rd_sh = {rd_q, qd_q[PW-1]};
	assign rn_ge = rn_sh >= {1'b0, g_q};
	assign rd_ge = rd_sh >= {1'b0, g_q};

	assign num_ext = XW'(qn_q);
	assign den_ext = XW'(qd_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= action_t'(action);
			an_neg_q <= a_num[W-1];
			ad_neg_q <= a_den[W-1];
			bn_neg_q <= b_num[W-1] ^ (action_t'(action) == ACT_SUB);
			bd_neg_q <= b_den[W-1];
			an_mag_q <= a_num[W-1] ? W'(-a_num) : W'(a_num);
			ad_mag_q <= a_den[W-1] ? W'(-a_den) : W'(a_den);
			bn_mag_q <= b_num[W-1] ? W'(-b_num) : W'(b_num);
			bd_mag_q <= b_den[W-1] ? W'(-b_den) : W'(b_den);
			t2_mag_q <= '0;
			t2_neg_q <= 1'b0;
		end
		case (cmd.mdst)
			DST_T1: begin
				t1_mag_q <= prod;
				t1_neg_q <= prod_neg;
			end
			DST_T2: begin
				t2_mag_q <= prod;
				t2_neg_q <= prod_neg;
			end
			DST_DEN: begin
				den_mag_q <= prod;
				den_neg_q <= prod_neg;
			end
			default: ;
		endcase
		if (cmd.sum) begin
			num_mag_q <= sum_mag;
			num_neg_q <= sum_neg;
			x_q       <= sum_mag;
			y_q       <= den_mag_q;
			k_q       <= '0;
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (cmd.div_init) begin
			g_q  <= (x_q | y_q) << k_q;
			rn_q <= '0;
			rd_q <= '0;
			qn_q <= num_mag_q;
			qd_q <= den_mag_q;
		end
		if (cmd.div_step) begin
			rn_q <= rn_ge ? PW'(rn_sh - {1'b0, g_q}) : rn_sh[PW-1:0];
			rd_q <= rd_ge ? PW'(rd_sh - {1'b0, g_q}) : rd_sh[PW-1:0];
			qn_q <= {qn_q[PW-2:0], rn_ge};
			qd_q <= {qd_q[PW-2:0], rd_ge};
		end
		if (cmd.load_res) begin
			res_num          <= RES_NUM_W'(num_neg_q ? -num_ext : num_ext);
			res_den          <= RES_DEN_W'(den_neg_q ? -den_ext : den_ext);
			zero_denominator <= 1'b0;
		end else if (cmd.load_err) begin
			res_num          <= '0;
			res_den          <= '0;
			zero_denominator <= 1'b1;
		end
	end

endmodule

// ===== rtl/rfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rational fraction ALU controller
// Sequences multiply, sum, GCD and division steps and raises the done strobe.
// ----------------------------------------------------------------------------
`include "rational_fraction_alu_macros.svh"

module rfa_ctrl #(
	parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  rfa_pkg::dp_sts_t  sts,
	output rfa_pkg::dp_cmd_t  cmd
);
	import rfa_pkg::*;

	localparam int STEPS = 2 * OPERAND_WIDTH;
	localparam int CW    = $clog2(STEPS);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL0  = 9'b000000010,
		S_MUL1  = 9'b000000100,
		S_MUL2  = 9'b000001000,
		S_SUM   = 9'b000010000,
		S_GCD   = 9'b000100000,
		S_DINIT = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.msel     = MSEL_AN_BD;
		cmd.mdst     = DST_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (sts.err) begin
						cmd.load_err = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d     = S_MUL0;
					end
				end
			end
			S_MUL0: begin
				cmd.msel = (sts.action == ACT_MUL) ? MSEL_AN_BN : MSEL_AN_BD;
				cmd.mdst = DST_T1;
				state_d  = S_MUL1;
			end
			S_MUL1: begin
				case (sts.action) inside
					ACT_ADD, ACT_SUB: begin
						cmd.msel = MSEL_AD_BN;
						cmd.mdst = DST_T2;
					end
					ACT_MUL: begin
						cmd.msel = MSEL_AD_BD;
						cmd.mdst = DST_DEN;
					end
					default: begin
						cmd.msel = MSEL_AD_BN;
						cmd.mdst = DST_DEN;
					end
				endcase
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.msel = MSEL_AD_BD;
				cmd.mdst = ((sts.action == ACT_ADD) || (sts.action == ACT_SUB)) ?
				           DST_DEN : DST_NONE;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_GCD;
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					state_d = S_DINIT;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CW'(STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.load_res = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.load_res || cmd.load_err;
			if (state_q == S_DINIT) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	`RFA_ASSERT_SAME(a_done_not_busy, clk, arst_n, done, !busy, "done raised while busy")
	`RFA_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy && !sts.err, busy,
		"valid request did not start work")
	`RFA_ASSERT_SAME(a_done_source, clk, arst_n, done,
		$past(state_q == S_FIN) || $past(start && !busy), "done without a source")

endmodule

// ===== verif/rfa_checker.sv =====
// ----------------------------------------------------------------------------
// Rational fraction ALU checker
// Watches the request and result channels of the rational fraction ALU, works
// out the reduced fraction or the zero denominator flag for every accepted
// request, and compares each result strobe with the oldest outstanding one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfa_checker
	import rfa_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [ACTION_W-1:0]         action,
	input  logic signed [15:0]          a_num,
	input  logic signed [15:0]          a_den,
	input  logic signed [15:0]          b_num,
	input  logic signed [15:0]          b_den,
	input  logic                        done,
	input  logic signed [RES_NUM_W-1:0] res_num,
	input  logic signed [RES_DEN_W-1:0] res_den,
	input  logic                        zero_denominator,
	output int                          mismatches,
	output int                          outstanding
);

	typedef struct {
		logic signed [RES_NUM_W-1:0] num;
		logic signed [RES_DEN_W-1:0] den;
		logic                        zero_den;
	} fraction_t;

	fraction_t expected_fractions[$];

	function automatic fraction_t reduced_fraction(action_t op, logic signed [15:0] an,
			logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
		longint    lan, lad, lbn, lbd;
		longint    n, d, x, y, t;
		fraction_t r;
		lan = an;
		lad = ad;
		lbn = bn;
		lbd = bd;
		r.num = '0;
		r.den = '0;
		r.zero_den = 1'b0;
		if (lad == 0 || lbd == 0 || (op == ACT_DIV && lbn == 0)) begin
			r.zero_den = 1'b1;
			return r;
		end
		case (op)
			ACT_ADD: begin
				n = lan * lbd + lad * lbn;
				d = lad * lbd;
			end
			ACT_SUB: begin
				n = lan * lbd - lad * lbn;
				d = lad * lbd;
			end
			ACT_MUL: begin
				n = lan * lbn;
				d = lad * lbd;
			end
			default: begin
				n = lan * lbd;
				d = lad * lbn;
			end
		endcase
		// gcd of the magnitudes; a zero numerator reduces by |d|
		x = (n < 0) ? -n : n;
		y = (d < 0) ? -d : d;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		n = n / x;
		d = d / x;
		r.num = n[RES_NUM_W-1:0];
		r.den = d[RES_DEN_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		fraction_t exp_f;
		if (!arst_n) begin
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (expected_fractions.size() == 0) begin
					$error("result strobe with no request outstanding");
					mismatches++;
				end else begin
					exp_f = expected_fractions.pop_front();
					if (res_num !== exp_f.num) begin
						$error("res_num: expected %0d, actual %0d", exp_f.num, res_num);
						mismatches++;
					end
					if (res_den !== exp_f.den) begin
						$error("res_den: expected %0d, actual %0d", exp_f.den, res_den);
						mismatches++;
					end
					if (zero_denominator !== exp_f.zero_den) begin
						$error("zero_denominator: expected %0b, actual %0b",
							exp_f.zero_den, zero_denominator);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				expected_fractions.push_back(reduced_fraction(action_t'(action),
					a_num, a_den, b_num, b_den));
			outstanding = expected_fractions.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Rational fraction ALU testbench
// Drives directed and random fraction requests through all four operations,
// with and without idle gaps between requests, and leaves the comparison of
// every result to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import rfa_pkg::*;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [ACTION_W-1:0]         action;
	logic signed [15:0]          a_num;
	logic signed [15:0]          a_den;
	logic signed [15:0]          b_num;
	logic signed [15:0]          b_den;
	logic                        done;
	logic signed [RES_NUM_W-1:0] res_num;
	logic signed [RES_DEN_W-1:0] res_den;
	logic                        zero_denominator;
	int                          mismatches;
	int                          outstanding;

	always #5 clk = ~clk;

	rational_fraction_alu DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.a_num(a_num),
		.a_den(a_den),
		.b_num(b_num),
		.b_den(b_den),
		.done(done),
		.res_num(res_num),
		.res_den(res_den),
		.zero_denominator(zero_denominator)
	);

	rfa_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.a_num(a_num),
		.a_den(a_den),
		.b_num(b_num),
		.b_den(b_den),
		.done(done),
		.res_num(res_num),
		.res_den(res_den),
		.zero_denominator(zero_denominator),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	function automatic logic signed [15:0] random_operand();
		logic signed [15:0] v;
		case ($urandom_range(9))
			4, 5: v = 16'($signed($urandom_range(40)) - 20);
			6: begin
				case ($urandom_range(4))
					0: v = -16'sd32768;
					1: v = 16'sd32767;
					2: v = -16'sd1;
					3: v = 16'sd1;
					default: v = '0;
				endcase
			end
			7: begin
				v = 16'($urandom_range(15, 1) << $urandom_range(11));
				if ($urandom_range(1))
					v = -v;
			end
			8, 9: v = 16'($signed($urandom_range(2000)) - 1000);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_request(action_t op, logic signed [15:0] an, logic signed [15:0] ad,
			logic signed [15:0] bn, logic signed [15:0] bd, int idle_pct);
		start <= 1'b1;
		action <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (busy);
		// hold off the next request with noise on the payload
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do begin
				action <= 2'($urandom);
				a_num <= 16'($urandom);
				a_den <= 16'($urandom);
				b_num <= 16'($urandom);
				b_den <= 16'($urandom);
				@(posedge clk);
			end while ($urandom_range(99) < idle_pct);
		end
	endtask

	initial begin
		#30_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int idle_phases[4];
		idle_phases = '{0, 49, 28, 0};
		arst_n = 1'b0;
		start = 1'b0;
		action = '0;
		a_num = '0;
		a_den = '0;
		b_num = '0;
		b_den = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 0);
		send_request(ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 0);
		send_request(ACT_MUL, 16'sd0, -16'sd5, 16'sd3, 16'sd7, 0);
		send_request(ACT_DIV, 16'sd3, 16'sd4, -16'sd6, 16'sd8, 0);
		send_request(ACT_ADD, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0);
		send_request(ACT_SUB, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 0);
		send_request(ACT_MUL, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 0);
		send_request(ACT_DIV, -16'sd32768, 16'sd1, 16'sd1, -16'sd32768, 0);
		send_request(ACT_ADD, 16'sd5, 16'sd0, 16'sd3, 16'sd4, 0);
		send_request(ACT_SUB, 16'sd5, 16'sd7, 16'sd3, 16'sd0, 0);
		send_request(ACT_MUL, 16'sd5, 16'sd0, 16'sd3, 16'sd0, 0);
		send_request(ACT_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd9, 0);
		send_request(ACT_DIV, 16'sd0, 16'sd3, 16'sd0, 16'sd5, 0);
		send_request(ACT_ADD, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1, 0);
		send_request(ACT_SUB, -16'sd32768, 16'sd1, 16'sd32767, 16'sd1, 0);
		send_request(ACT_MUL, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 0);
		send_request(ACT_DIV, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 0);
		send_request(ACT_ADD, 16'sd12, -16'sd18, 16'sd5, -16'sd30, 0);
		send_request(ACT_MUL, 16'sd6, 16'sd4, 16'sd10, 16'sd15, 0);
		send_request(ACT_DIV, 16'sd0, -16'sd7, 16'sd3, 16'sd5, 0);
		send_request(ACT_SUB, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 0);
		send_request(ACT_ADD, 16'sd1, -16'sd32768, 16'sd0, 16'sd1, 0);

		foreach (idle_phases[p])
			repeat (425)
				send_request(action_t'($urandom_range(3)), random_operand(),
					random_operand(), random_operand(), random_operand(), idle_phases[p]);

		start <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (150) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rfa_pkg.sv
rtl/rfa_datapath.sv
rtl/rfa_ctrl.sv
rtl/rational_fraction_alu.sv
verif/rfa_checker.sv
verif/tb_top.sv
